// File: rtl/rpd_pkg.sv
// Shared types and constants for the ring priority dispatcher.
// No dependencies; imported by every module of the block.
`default_nettype none

package rpd_pkg;

   localparam int SLOTS_DEFAULT = 16;
   localparam int ID_W          = 8;
   localparam int PRIO_W        = 8;
   localparam int REQ_DATA_W    = 24;
   localparam int RSP_DATA_W    = 16;

   typedef enum logic [1:0] {
      FN_ADD      = 2'd0,
      FN_DISPATCH = 2'd1,
      FN_COMPLETE = 2'd2
   } func_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2,
      ST_NONE  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_SWAP,
      S_DONE
   } state_type;

   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [PRIO_W-1:0] prio;
   } entry_type;

   typedef struct packed {
      logic [1:0]        func;
      logic [ID_W-1:0]   proc_id;
      logic [PRIO_W-1:0] prio;
      logic              repeat_req;
   } req_type;

   typedef struct packed {
      status_type        status;
      logic [ID_W-1:0]   out_id;
      logic [PRIO_W-1:0] out_prio;
   } result_type;

endpackage

`default_nettype wire

// File: rtl/rpd_mem.sv
// Slot memory: one write port, one read port, registered read data.
// Depends on rpd_pkg for the entry type.
`default_nettype none

module rpd_mem #(
   parameter int DEPTH  = rpd_pkg::SLOTS_DEFAULT,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic               clock,
   input  wire logic               wr_en,
   input  wire logic [ADDR_W-1:0]  wr_addr,
   input  wire rpd_pkg::entry_type wr_data,
   input  wire logic               rd_en,
   input  wire logic [ADDR_W-1:0]  rd_addr,
   output rpd_pkg::entry_type      rd_data
);
   import rpd_pkg::*;

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/rpd_ctrl.sv
// Sequencer: ring pointers, last dispatched entry, scan over the slot memory.
// Depends on rpd_pkg; drives the ports of rpd_mem.
`default_nettype none

module rpd_ctrl #(
   parameter int SLOTS  = rpd_pkg::SLOTS_DEFAULT,
   parameter int PTR_W  = $clog2(SLOTS)
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire rpd_pkg::req_type    req,
   output logic                     res_valid,
   input  wire logic                res_ready,
   output rpd_pkg::result_type      res,
   output logic                     mem_wr_en,
   output logic [PTR_W-1:0]         mem_wr_addr,
   output rpd_pkg::entry_type       mem_wr_data,
   output logic                     mem_rd_en,
   output logic [PTR_W-1:0]         mem_rd_addr,
   input  wire rpd_pkg::entry_type  mem_rd_data
);
   import rpd_pkg::*;

   function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
      if (p == PTR_W'(SLOTS - 1)) begin
         return '0;
      end
      return p + 1'b1;
   endfunction

   state_type        state_ff,      state_in;
   logic [PTR_W-1:0] head_ff,       head_in;
   logic [PTR_W-1:0] tail_ff,       tail_in;
   entry_type        last_ff,       last_in;
   logic             last_valid_ff, last_valid_in;
   logic [PTR_W-1:0] iss_ff,        iss_in;
   logic [PTR_W-1:0] da_ff,         da_in;
   logic             dv_ff,         dv_in;
   logic [PTR_W-1:0] best_addr_ff,  best_addr_in;
   entry_type        best_ff,       best_in;
   entry_type        head_ent_ff,   head_ent_in;
   result_type       res_ff,        res_in;

   logic     ring_full;
   logic     ring_empty;
   logic     first_data;
   func_type func;

   assign ring_full  = (ring_next(tail_ff) == head_ff);
   assign ring_empty = (head_ff == tail_ff);
   assign first_data = (da_ff == head_ff);
   assign func       = func_type'(req.func);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         head_ff       <= '0;
         tail_ff       <= '0;
         last_ff       <= '0;
         last_valid_ff <= 1'b0;
         dv_ff         <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         last_ff       <= last_in;
         last_valid_ff <= last_valid_in;
         dv_ff         <= dv_in;
      end
      iss_ff       <= iss_in;
      da_ff        <= da_in;
      best_addr_ff <= best_addr_in;
      best_ff      <= best_in;
      head_ent_ff  <= head_ent_in;
      res_ff       <= res_in;
   end

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      last_in       = last_ff;
      last_valid_in = last_valid_ff;
      iss_in        = iss_ff;
      da_in         = da_ff;
      dv_in         = 1'b0;
      best_addr_in  = best_addr_ff;
      best_in       = best_ff;
      head_ent_in   = head_ent_ff;
      res_in        = res_ff;
      req_ready     = 1'b0;
      res_valid     = 1'b0;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = tail_ff;
      mem_wr_data   = '{id: req.proc_id, prio: req.prio};
      mem_rd_en     = 1'b0;
      mem_rd_addr   = head_ff;

      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               res_in   = '{status: ST_OK, out_id: '0, out_prio: '0};
               state_in = S_DONE;
               case (func)
                  FN_ADD: begin
                     if (ring_full) begin
                        res_in.status = ST_FULL;
                     end else begin
                        mem_wr_en = 1'b1;
                        tail_in   = ring_next(tail_ff);
                     end
                  end
                  FN_DISPATCH: begin
                     if (ring_empty) begin
                        res_in.status = ST_EMPTY;
                     end else begin
                        // first read is the head entry
                        mem_rd_en = 1'b1;
                        da_in     = head_ff;
                        dv_in     = 1'b1;
                        iss_in    = ring_next(head_ff);
                        state_in  = S_SCAN;
                     end
                  end
                  FN_COMPLETE: begin
                     if (!last_valid_ff) begin
                        res_in.status = ST_NONE;
                     end else begin
                        last_valid_in = 1'b0;
                        if (req.repeat_req) begin
                           if (ring_full) begin
                              res_in.status = ST_FULL;
                           end else begin
                              mem_wr_en   = 1'b1;
                              mem_wr_data = last_ff;
                              tail_in     = ring_next(tail_ff);
                           end
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_SCAN: begin
            if (dv_ff) begin
               if (first_data) begin
                  head_ent_in = mem_rd_data;
               end
               // strict compare keeps the earliest entry on a tie
               if (first_data || (mem_rd_data.prio < best_ff.prio)) begin
                  best_in      = mem_rd_data;
                  best_addr_in = da_ff;
               end
            end
            if (iss_ff != tail_ff) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = iss_ff;
               da_in       = iss_ff;
               dv_in       = 1'b1;
               iss_in      = ring_next(iss_ff);
            end else begin
               state_in = S_SWAP;
            end
         end
         S_SWAP: begin
            // old head entry moves into the winner's slot; head slot is popped
            mem_wr_en     = 1'b1;
            mem_wr_addr   = best_addr_ff;
            mem_wr_data   = head_ent_ff;
            res_in        = '{status: ST_OK, out_id: best_ff.id, out_prio: best_ff.prio};
            last_in       = best_ff;
            last_valid_in = 1'b1;
            head_in       = ring_next(head_ff);
            state_in      = S_DONE;
         end
         S_DONE: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign res = res_ff;

endmodule

`default_nettype wire

// File: rtl/ring_priority_dispatcher.sv
// Top level of the ring priority dispatcher: stream ports and output register.
// Depends on rpd_pkg, rpd_mem and rpd_ctrl.
`default_nettype none

// Ring of SLOTS process entries (SLOTS-1 usable) kept in one slot memory with a
// registered read. An item is taken when req_tready is high, one at a time. A
// dispatch of a non-empty ring walks the occupied slots from the head with one
// memory read per cycle, then writes the swapped entry back and hands the result
// to the output register. The result waits in an output register, so the next
// item can be accepted while rsp_tvalid is held against a low rsp_tready.
// Dispatch output fields are zero unless the dispatch succeeds.
module ring_priority_dispatcher #(
   parameter int SLOTS = rpd_pkg::SLOTS_DEFAULT
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   // [7:0] proc_id, [15:8] prio, [16] repeat_req, [23:17] zero
   input  wire logic [rpd_pkg::REQ_DATA_W-1:0] req_tdata,
   // [1:0] func
   input  wire logic [1:0]                     req_tuser,
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   // [7:0] out_id, [15:8] out_prio
   output logic [rpd_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // [1:0] status
   output logic [1:0]                          rsp_tuser
);
   import rpd_pkg::*;

   localparam int PTR_W = $clog2(SLOTS);

   req_type          req;
   result_type       res;
   logic             res_valid;
   logic             res_ready;
   logic             mem_wr_en;
   logic [PTR_W-1:0] mem_wr_addr;
   entry_type        mem_wr_data;
   logic             mem_rd_en;
   logic [PTR_W-1:0] mem_rd_addr;
   entry_type        mem_rd_data;

   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff,       rsp_in;

   assign req = '{func:       req_tuser,
                  proc_id:    req_tdata[7:0],
                  prio:       req_tdata[15:8],
                  repeat_req: req_tdata[16]};

   rpd_ctrl #(
      .SLOTS (SLOTS),
      .PTR_W (PTR_W)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req         (req),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res         (res),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   rpd_mem #(
      .DEPTH  (SLOTS),
      .ADDR_W (PTR_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_ff.out_prio, rsp_ff.out_id};
   assign rsp_tuser  = rsp_ff.status;

   // one transaction in flight: acceptance closes the input until the result is handed to the output register
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input accepted while an item is in work");

   // only a successful dispatch carries a nonzero payload
   a_zero_payload: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser != ST_OK)) |-> (rsp_tdata == '0))
      else $error("nonzero payload on a failed transaction");

   // a handed-over result shows up on the output next cycle
   a_result_lands: assert property (@(posedge clock) disable iff (reset)
      (res_valid && res_ready) |=> rsp_tvalid)
      else $error("result lost between sequencer and output register");

endmodule

`default_nettype wire

// File: test/tb_top.sv
// Self-checking testbench for ring_priority_dispatcher: a queue-fed stream driver,
// a ring predictor and a result monitor. Depends on rpd_pkg and the RTL top level.
`default_nettype none

module tb_top;
   import rpd_pkg::*;

   localparam int SLOTS       = SLOTS_DEFAULT;
   localparam int LIMIT       = 400000;
   localparam int RANDOM_ITEMS = 700;
   localparam func_type FN_UNUSED = func_type'(2'd3);

   typedef struct {
      func_type          func;
      logic [ID_W-1:0]   id;
      logic [PRIO_W-1:0] prio;
      logic              rep;
   } req_item;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [1:0]            req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [1:0]            rsp_tuser;

   ring_priority_dispatcher #(.SLOTS(SLOTS)) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   req_item    req_backlog[$];
   result_type rsp_expected[$];
   req_item    req_on_bus;
   req_item    req_next;
   int         sent_count = 0;
   int         rcvd_count = 0;
   int         error_count = 0;
   int         cycle_count = 0;
   bit         calm;

   // predictor state
   logic [ID_W-1:0]   ring_id[SLOTS];
   logic [PRIO_W-1:0] ring_prio[SLOTS];
   int                ring_head = 0;
   int                ring_tail = 0;
   logic [ID_W-1:0]   done_id = '0;
   logic [PRIO_W-1:0] done_prio = '0;
   logic              done_valid = 1'b0;

   // no idling on either side for a stretch in the middle of the run
   assign calm = (sent_count >= 300) && (sent_count < 420);

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic status_type ring_push(logic [ID_W-1:0] id, logic [PRIO_W-1:0] prio);
      int nt;
      nt = (ring_tail + 1) % SLOTS;
      if (nt == ring_head) return ST_FULL;
      ring_id[ring_tail]   = id;
      ring_prio[ring_tail] = prio;
      ring_tail            = nt;
      return ST_OK;
   endfunction

   function automatic result_type dispatch_predict(req_item it);
      result_type r;
      int best;
      int p;
      logic [7:0] t;
      r.status   = ST_OK;
      r.out_id   = '0;
      r.out_prio = '0;
      case (it.func)
         FN_ADD: begin
            r.status = ring_push(it.id, it.prio);
         end
         FN_DISPATCH: begin
            if (ring_head == ring_tail) begin
               r.status = ST_EMPTY;
            end else begin
               best = ring_head;
               p    = (ring_head + 1) % SLOTS;
               // strict less-than keeps the earliest entry on a tie
               while (p != ring_tail) begin
                  if (ring_prio[p] < ring_prio[best]) best = p;
                  p = (p + 1) % SLOTS;
               end
               t                    = ring_id[ring_head];
               ring_id[ring_head]   = ring_id[best];
               ring_id[best]        = t;
               t                    = ring_prio[ring_head];
               ring_prio[ring_head] = ring_prio[best];
               ring_prio[best]      = t;
               r.out_id   = ring_id[ring_head];
               r.out_prio = ring_prio[ring_head];
               ring_head  = (ring_head + 1) % SLOTS;
               done_id    = r.out_id;
               done_prio  = r.out_prio;
               done_valid = 1'b1;
            end
         end
         FN_COMPLETE: begin
            if (!done_valid) begin
               r.status = ST_NONE;
            end else begin
               if (it.rep) r.status = ring_push(done_id, done_prio);
               done_valid = 1'b0;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic queue_item(func_type func, int id, int prio, bit rep);
      req_item it;
      it.func = func;
      it.id   = id[7:0];
      it.prio = prio[7:0];
      it.rep  = rep;
      req_backlog.push_back(it);
   endtask

   // driver: one transaction in flight, held until accepted
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_tuser  <= '0;
      end else begin
         if (req_tvalid && req_tready) begin
            rsp_expected.push_back(dispatch_predict(req_on_bus));
         end
         if (!req_tvalid || req_tready) begin
            if (req_backlog.size() != 0 && (calm || $urandom_range(99) >= 26)) begin
               req_next   = req_backlog.pop_front();
               req_on_bus = req_next;
               req_tvalid <= 1'b1;
               req_tdata  <= {7'b0, req_next.rep, req_next.prio, req_next.id};
               req_tuser  <= req_next.func;
               sent_count++;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor: compare each result transaction with the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            rcvd_count++;
            if (rsp_expected.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("unexpected result: status %0d id %0d prio %0d",
                           rsp_tuser, rsp_tdata[7:0], rsp_tdata[15:8]);
            end else begin
               result_type want;
               want = rsp_expected.pop_front();
               if (rsp_tuser != want.status || rsp_tdata[7:0] != want.out_id ||
                   rsp_tdata[15:8] != want.out_prio) begin
                  error_count++;
                  if (error_count <= 10)
                     $display("mismatch: expected status %0d id %0d prio %0d, got %0d %0d %0d",
                              want.status, want.out_id, want.out_prio,
                              rsp_tuser, rsp_tdata[7:0], rsp_tdata[15:8]);
               end
            end
         end
         rsp_tready <= calm || ($urandom_range(99) >= 26);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      int mode;
      int pick;
      int pr;
      // directed part
      queue_item(FN_DISPATCH, 8'hA5, 8'h5A, 1'b1);   // dispatch from empty ring
      queue_item(FN_COMPLETE, 0, 0, 1'b1);           // nothing to complete
      queue_item(FN_UNUSED, 255, 255, 1'b1);         // unused code
      queue_item(FN_ADD, 0, 255, 1'b0);
      queue_item(FN_ADD, 255, 0, 1'b1);
      queue_item(FN_ADD, 17, 0, 1'b0);               // tie at the lowest priority value
      for (int i = 0; i < 12; i++) queue_item(FN_ADD, 32 + i, (i * 37) % 256, i[0]);
      queue_item(FN_ADD, 99, 1, 1'b0);               // ring full
      queue_item(FN_DISPATCH, 0, 0, 1'b0);
      queue_item(FN_ADD, 200, 128, 1'b0);            // fills the ring again
      queue_item(FN_COMPLETE, 0, 0, 1'b1);           // requeue onto a full ring
      queue_item(FN_DISPATCH, 0, 0, 1'b0);
      queue_item(FN_COMPLETE, 0, 0, 1'b0);           // complete without requeue
      queue_item(FN_COMPLETE, 0, 0, 1'b1);

      // random part: segments biased toward filling, draining or balanced
      mode = 0;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 50 == 0) mode = $urandom_range(2);
         pick = $urandom_range(99);
         pr   = ($urandom_range(1) != 0) ? $urandom_range(7) : $urandom_range(255);
         if (pick < 3) begin
            queue_item(FN_UNUSED, $urandom_range(255), pr, 1'($urandom_range(1)));
         end else if (pick < (mode == 0 ? 65 : (mode == 1 ? 22 : 42))) begin
            queue_item(FN_ADD, $urandom_range(255), pr, 1'($urandom_range(1)));
         end else if (pick < (mode == 0 ? 87 : (mode == 1 ? 75 : 75))) begin
            queue_item(FN_DISPATCH, $urandom_range(255), pr, 1'($urandom_range(1)));
         end else begin
            queue_item(FN_COMPLETE, $urandom_range(255), pr, 1'($urandom_range(1)));
         end
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // every transaction sent has to come back before the verdict
      while (req_backlog.size() != 0 || rcvd_count < sent_count) @(posedge clock);
      while (rsp_expected.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

`default_nettype wire
